// ===== rtl/rcc_pkg.sv =====
// shared types and constants of the rc channel conditioner
`default_nettype none
package rcc_pkg;

  localparam int KIND_W = 3;
  localparam int CIDX_W = 4;
  localparam int RAW_W  = 12;
  localparam int GAP_W  = 24;
  localparam int MODE_W = 8;
  localparam int VAL_W  = 18;
  localparam int QUAL_W = 2;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_SAMPLE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FRAME    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TICK     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CALIB    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MODE_REQ = 3'd4;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_SCALE    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_DEADZONE = 3'd1;
  localparam logic [CFG_AW-1:0] REG_INVERT   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_CHMAP    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MODETAB  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_GOOD_GAP = 3'd5;
  localparam logic [CFG_AW-1:0] REG_LOST_GAP = 3'd6;

  localparam logic [QUAL_W-1:0] QUAL_GOOD = 2'd0;
  localparam logic [QUAL_W-1:0] QUAL_BAD  = 2'd1;
  localparam logic [QUAL_W-1:0] QUAL_LOST = 2'd2;

  localparam logic [1:0] PEND_NONE   = 2'd0;
  localparam logic [1:0] PEND_ARM    = 2'd1;
  localparam logic [1:0] PEND_DISARM = 2'd2;

  localparam logic [MODE_W-1:0] MASK_ARMED  = 8'h80;
  localparam logic [MODE_W-1:0] MASK_HIL    = 8'h20;
  localparam logic [MODE_W-1:0] MASK_TEST   = 8'h02;
  localparam logic [MODE_W-1:0] MASK_CUSTOM = 8'h01;

  // stick thresholds in q.14
  localparam logic signed [VAL_W-1:0] TH_STICK_LOW = -18'sd15565;
  localparam logic signed [VAL_W-1:0] TH_HI        = 18'sd14746;
  localparam logic signed [VAL_W-1:0] TH_LO        = -18'sd14746;
  localparam logic signed [VAL_W-1:0] TH_HALF      = 18'sd8192;
  localparam logic signed [VAL_W-1:0] TH_NEG_HALF  = -18'sd8192;
  localparam logic signed [VAL_W-1:0] FAILSAFE_THR = -18'sd16384;

  typedef struct packed {
    logic [15:0]       scale;
    logic [10:0]       deadzone;
    logic [15:0]       invert;
    logic [3:0]        safety_ch;
    logic [3:0]        mode_ch;
    logic [3:0]        custom_ch;
    logic [3:0]        test_ch;
    logic [3:0]        dis_ch;
    logic              use_custom;
    logic              use_test;
    logic              use_dis;
    logic [31:0]       mode_table;
    logic [GAP_W-1:0]  good_gap;
    logic [GAP_W-1:0]  lost_gap;
  } cfg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] channel_value;
    logic [QUAL_W-1:0]       signal_quality;
    logic [MODE_W-1:0]       desired_mode;
    logic [MODE_W-1:0]       merged_mode;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/rcc_ifs.sv =====
// request and result channel interfaces
`default_nettype none
interface rcc_in_if;
  logic                        valid;
  logic                        ready;
  logic [rcc_pkg::KIND_W-1:0]  kind;
  logic [rcc_pkg::CIDX_W-1:0]  channel_index;
  logic signed [rcc_pkg::RAW_W-1:0] raw_value;
  logic [rcc_pkg::GAP_W-1:0]   frame_gap_us;
  logic [rcc_pkg::GAP_W-1:0]   elapsed_us;
  logic [rcc_pkg::MODE_W-1:0]  running_mode;

  modport source (
    output valid, kind, channel_index, raw_value, frame_gap_us, elapsed_us, running_mode,
    input  ready
  );
  modport sink (
    input  valid, kind, channel_index, raw_value, frame_gap_us, elapsed_us, running_mode,
    output ready
  );
endinterface

interface rcc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rcc_pkg::VAL_W-1:0]  channel_value;
  logic [rcc_pkg::QUAL_W-1:0]        signal_quality;
  logic [rcc_pkg::MODE_W-1:0]        desired_mode;
  logic [rcc_pkg::MODE_W-1:0]        merged_mode;

  modport source (
    output valid, channel_value, signal_quality, desired_mode, merged_mode,
    input  ready
  );
  modport sink (
    input  valid, channel_value, signal_quality, desired_mode, merged_mode,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/rcc_cfg.sv =====
// configuration register file with field decode
`default_nettype none
module rcc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rcc_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [rcc_pkg::CFG_DW-1:0]  cfg_wdata,
  output rcc_pkg::cfg_t               cfg
);

  logic [15:0] scale_r;
  logic [10:0] deadzone_r;
  logic [13:0] invert_r;
  logic [22:0] chmap_r;
  logic [31:0] modetab_r;
  logic [23:0] good_gap_r;
  logic [23:0] lost_gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r    <= 16'd74;
      deadzone_r <= 11'd30;
      invert_r   <= '0;
      chmap_r    <= '0;
      modetab_r  <= '0;
      good_gap_r <= 24'd100000;
      lost_gap_r <= 24'd1500000;
    end else if (cfg_we) begin
      case (cfg_index)
        rcc_pkg::REG_SCALE:    scale_r    <= cfg_wdata[15:0];
        rcc_pkg::REG_DEADZONE: deadzone_r <= cfg_wdata[10:0];
        rcc_pkg::REG_INVERT:   invert_r   <= cfg_wdata[13:0];
        rcc_pkg::REG_CHMAP:    chmap_r    <= cfg_wdata[22:0];
        rcc_pkg::REG_MODETAB:  modetab_r  <= cfg_wdata[31:0];
        rcc_pkg::REG_GOOD_GAP: good_gap_r <= cfg_wdata[23:0];
        rcc_pkg::REG_LOST_GAP: lost_gap_r <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.scale      = scale_r;
    cfg.deadzone   = deadzone_r;
    cfg.invert     = {2'b00, invert_r};
    cfg.safety_ch  = chmap_r[3:0];
    cfg.mode_ch    = chmap_r[7:4];
    cfg.custom_ch  = chmap_r[11:8];
    cfg.test_ch    = chmap_r[15:12];
    cfg.dis_ch     = chmap_r[19:16];
    cfg.use_custom = chmap_r[20];
    cfg.use_test   = chmap_r[21];
    cfg.use_dis    = chmap_r[22];
    cfg.mode_table = modetab_r;
    cfg.good_gap   = good_gap_r;
    cfg.lost_gap   = lost_gap_r;
  end

endmodule
`default_nettype wire

// ===== rtl/rcc_core.sv =====
// channel and trim memories with the read-modify-write sequencer and mode logic
`default_nettype none
module rcc_core #(
  parameter int CHANNEL_COUNT = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rcc_pkg::cfg_t       cfg,
  rcc_in_if.sink              in_chan,
  output logic                res_valid,
  input  logic                res_ready,
  output rcc_pkg::res_t       res
);

  localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [4:0] CH_N = 5'(CHANNEL_COUNT);
  localparam int VW = rcc_pkg::VAL_W;

  // read steps; frame-done walks all of them, other requests use the first only
  localparam logic [3:0] STEP_THR    = 4'd0;
  localparam logic [3:0] STEP_ROLL   = 4'd1;
  localparam logic [3:0] STEP_PITCH  = 4'd2;
  localparam logic [3:0] STEP_YAW    = 4'd3;
  localparam logic [3:0] STEP_DIS    = 4'd4;
  localparam logic [3:0] STEP_SAFETY = 4'd5;
  localparam logic [3:0] STEP_MODE   = 4'd6;
  localparam logic [3:0] STEP_CUSTOM = 4'd7;
  localparam logic [3:0] STEP_TEST   = 4'd8;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_LAST, S_CALC} state_t;

  function automatic logic signed [VW-1:0] sat18(input logic signed [28:0] v);
    if (v > 29'sd131071) sat18 = 18'sh1ffff;
    else if (v < -29'sd131072) sat18 = 18'sh20000;
    else sat18 = v[VW-1:0];
  endfunction

  state_t                     state_r;
  logic [3:0]                 step_r;
  logic                       rd_pend_r;
  logic [3:0]                 rd_tag_r;
  logic [rcc_pkg::QUAL_W-1:0] quality_r;
  logic [rcc_pkg::MODE_W-1:0] wanted_r;
  logic [1:0]                 pending_r;
  logic [CHANNEL_COUNT-1:0]   chan_vld_r;
  logic [CHANNEL_COUNT-1:0]   trim_vld_r;

  logic signed [VW-1:0] chan_mem [CHANNEL_COUNT];
  logic signed [VW-1:0] trim_mem [CHANNEL_COUNT];
  logic signed [VW-1:0] chan_q_r;
  logic signed [VW-1:0] trim_q_r;
  logic                 chan_vq_r;
  logic                 trim_vq_r;

  // request payload
  logic [rcc_pkg::KIND_W-1:0] kind_r;
  logic [rcc_pkg::CIDX_W-1:0] ch_r;
  logic                       ch_ok_r;
  logic                       dz_hit_r;
  logic                       inv_r;
  logic signed [28:0]         prod_r;
  logic signed [28:0]         v_r;
  logic [rcc_pkg::GAP_W-1:0]  gap_r;
  logic [rcc_pkg::GAP_W-1:0]  elapsed_r;
  logic [rcc_pkg::MODE_W-1:0] running_r;

  // captured reads
  logic signed [VW-1:0] a_val_r;
  logic signed [VW-1:0] t_val_r;
  logic thr_low_r, roll_hi_r, roll_lo_r, pitch_hi_r, yaw_hi_r, yaw_lo_r;
  logic dis_low_r, safety_on_r, sw_up_r, sw_mid_r, custom_on_r, test_on_r;

  logic                  accept;
  logic [3:0]            rd_idx;
  logic                  rd_ok;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic signed [VW-1:0]  chan_rd;
  logic signed [VW-1:0]  trim_rd;
  logic signed [12:0]    raw_x13;
  logic signed [12:0]    dz_x13;
  logic signed [28:0]    raw_x;
  logic signed [28:0]    scl_x;
  logic signed [28:0]    rnd;
  logic signed [28:0]    q4;
  logic signed [VW-1:0]  new_val;
  logic signed [VW-1:0]  new_trim;
  logic                  failsafe;
  logic                  commit;
  logic                  chan_we;
  logic                  trim_we;
  logic signed [VW-1:0]  chan_wdata;
  logic [rcc_pkg::QUAL_W-1:0] quality_nxt;
  logic [rcc_pkg::MODE_W-1:0] wanted_nxt;
  logic [1:0]                 pending_nxt;
  logic [rcc_pkg::MODE_W-1:0] merged;
  logic [rcc_pkg::MODE_W-1:0] nm;
  logic                       armed;
  logic [1:0]                 pend_frame;
  logic                       arm_combo;
  logic                       disarm_combo;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && (state_r == S_IDLE);

  // read address of the current step
  always_comb begin
    rd_idx = 4'd0;
    case (step_r)
      STEP_THR: begin
        if (kind_r == rcc_pkg::KIND_SAMPLE || kind_r == rcc_pkg::KIND_CALIB) rd_idx = ch_r;
        else rd_idx = 4'd0;
      end
      STEP_ROLL:   rd_idx = 4'd1;
      STEP_PITCH:  rd_idx = 4'd2;
      STEP_YAW:    rd_idx = 4'd3;
      STEP_DIS:    rd_idx = cfg.dis_ch;
      STEP_SAFETY: rd_idx = cfg.safety_ch;
      STEP_MODE:   rd_idx = cfg.mode_ch;
      STEP_CUSTOM: rd_idx = cfg.custom_ch;
      STEP_TEST:   rd_idx = cfg.test_ch;
      default:     rd_idx = 4'd0;
    endcase
  end

  assign rd_ok   = ({1'b0, rd_idx} < CH_N);
  assign rd_addr = rd_ok ? rd_idx[AW-1:0] : '0;
  assign wr_addr = (kind_r == rcc_pkg::KIND_TICK || !ch_ok_r) ? '0 : ch_r[AW-1:0];

  // memories: one registered read per cycle, writes only at commit
  always_ff @(posedge clk) begin
    if (chan_we) chan_mem[wr_addr] <= chan_wdata;
    if (trim_we) trim_mem[wr_addr] <= new_trim;
    if (state_r == S_READ) begin
      chan_q_r  <= chan_mem[rd_addr];
      trim_q_r  <= trim_mem[rd_addr];
      chan_vq_r <= chan_vld_r[rd_addr] && rd_ok;
      trim_vq_r <= trim_vld_r[rd_addr] && rd_ok;
    end
  end

  // never-written entries read as zero
  assign chan_rd = chan_vq_r ? chan_q_r : '0;
  assign trim_rd = trim_vq_r ? trim_q_r : '0;

  assign raw_x13 = {in_chan.raw_value[rcc_pkg::RAW_W-1], in_chan.raw_value};
  assign dz_x13  = {2'b00, cfg.deadzone};
  assign raw_x   = {{17{in_chan.raw_value[rcc_pkg::RAW_W-1]}}, in_chan.raw_value};
  assign scl_x   = {13'd0, cfg.scale};
  assign rnd     = prod_r + 29'sd2;
  assign q4      = rnd >>> 2;

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= in_chan.kind;
      ch_r      <= in_chan.channel_index;
      ch_ok_r   <= ({1'b0, in_chan.channel_index} < CH_N);
      dz_hit_r  <= (raw_x13 < dz_x13) && (raw_x13 > -dz_x13);
      inv_r     <= cfg.invert[in_chan.channel_index];
      prod_r    <= raw_x * scl_x;
      gap_r     <= in_chan.frame_gap_us;
      elapsed_r <= in_chan.elapsed_us;
      running_r <= in_chan.running_mode;
    end
    if (state_r == S_READ) begin
      v_r <= inv_r ? -q4 : q4;
    end
    if (rd_pend_r) begin
      case (rd_tag_r)
        STEP_THR: begin
          a_val_r   <= chan_rd;
          t_val_r   <= trim_rd;
          thr_low_r <= (chan_rd <= rcc_pkg::TH_STICK_LOW);
        end
        STEP_ROLL: begin
          roll_hi_r <= (chan_rd >= rcc_pkg::TH_HI);
          roll_lo_r <= (chan_rd <= rcc_pkg::TH_LO);
        end
        STEP_PITCH: pitch_hi_r <= (chan_rd >= rcc_pkg::TH_HI);
        STEP_YAW: begin
          yaw_hi_r <= (chan_rd >= rcc_pkg::TH_HI);
          yaw_lo_r <= (chan_rd <= rcc_pkg::TH_LO);
        end
        STEP_DIS:    dis_low_r   <= (chan_rd < rcc_pkg::TH_HALF);
        STEP_SAFETY: safety_on_r <= (chan_rd > 18'sd0);
        STEP_MODE: begin
          sw_up_r  <= (chan_rd >= rcc_pkg::TH_HALF);
          sw_mid_r <= (chan_rd > rcc_pkg::TH_NEG_HALF);
        end
        STEP_CUSTOM: custom_on_r <= (chan_rd > 18'sd0);
        STEP_TEST:   test_on_r   <= (chan_rd > 18'sd0);
        default: ;
      endcase
    end
  end

  assign new_val  = dz_hit_r ? '0 : sat18(v_r - {{11{t_val_r[VW-1]}}, t_val_r});
  assign new_trim = sat18({{11{a_val_r[VW-1]}}, a_val_r} - {{11{t_val_r[VW-1]}}, t_val_r});
  assign failsafe = (elapsed_r > cfg.lost_gap);

  assign arm_combo    = thr_low_r && yaw_lo_r && pitch_hi_r && roll_hi_r;
  assign disarm_combo = thr_low_r && yaw_hi_r && pitch_hi_r && roll_lo_r;

  // mode selection for a frame-done request
  always_comb begin
    armed      = wanted_r[7];
    pend_frame = pending_r;
    if (arm_combo) begin
      armed      = 1'b1;
      pend_frame = rcc_pkg::PEND_ARM;
    end else if (disarm_combo) begin
      armed      = 1'b0;
      pend_frame = rcc_pkg::PEND_DISARM;
    end
    if (safety_on_r) begin
      nm = cfg.mode_table[7:0];
      nm = armed ? (nm | rcc_pkg::MASK_ARMED) : (nm & ~rcc_pkg::MASK_ARMED);
    end else begin
      if (sw_up_r) nm = cfg.mode_table[15:8];
      else if (sw_mid_r) nm = cfg.mode_table[23:16];
      else nm = cfg.mode_table[31:24];
      if (cfg.use_custom) begin
        nm = custom_on_r ? (nm | rcc_pkg::MASK_CUSTOM) : (nm & ~rcc_pkg::MASK_CUSTOM);
      end
      if (cfg.use_test) begin
        nm = test_on_r ? (nm | rcc_pkg::MASK_TEST) : (nm & ~rcc_pkg::MASK_TEST);
      end
      if (!armed) nm = nm & ~rcc_pkg::MASK_ARMED;
      else nm = (nm & ~rcc_pkg::MASK_ARMED) | (wanted_r & rcc_pkg::MASK_ARMED);
    end
  end

  // next state and result of the request under commit
  always_comb begin
    quality_nxt       = quality_r;
    wanted_nxt        = wanted_r;
    pending_nxt       = pending_r;
    merged            = '0;
    res.channel_value = a_val_r;
    case (kind_r)
      rcc_pkg::KIND_SAMPLE: res.channel_value = ch_ok_r ? new_val : '0;
      rcc_pkg::KIND_CALIB:  res.channel_value = ch_ok_r ? new_trim : '0;
      rcc_pkg::KIND_FRAME: begin
        if (gap_r < cfg.good_gap) quality_nxt = rcc_pkg::QUAL_GOOD;
        else if (gap_r < cfg.lost_gap) quality_nxt = rcc_pkg::QUAL_BAD;
        // disable switch low freezes the mode state
        if (!(cfg.use_dis && dis_low_r)) begin
          wanted_nxt  = nm;
          pending_nxt = pend_frame;
        end
      end
      rcc_pkg::KIND_TICK: begin
        if (failsafe) begin
          quality_nxt       = rcc_pkg::QUAL_LOST;
          res.channel_value = rcc_pkg::FAILSAFE_THR;
        end
      end
      rcc_pkg::KIND_MODE_REQ: begin
        merged = (wanted_r & ~(rcc_pkg::MASK_ARMED | rcc_pkg::MASK_HIL))
               | (running_r & (rcc_pkg::MASK_ARMED | rcc_pkg::MASK_HIL));
        if (pending_r == rcc_pkg::PEND_ARM) begin
          merged      = merged | rcc_pkg::MASK_ARMED;
          pending_nxt = rcc_pkg::PEND_NONE;
        end else if (pending_r == rcc_pkg::PEND_DISARM) begin
          merged      = merged & ~rcc_pkg::MASK_ARMED;
          pending_nxt = rcc_pkg::PEND_NONE;
        end
      end
      default: ;
    endcase
    res.signal_quality = quality_nxt;
    res.desired_mode   = wanted_nxt;
    res.merged_mode    = merged;
  end

  assign res_valid  = (state_r == S_CALC);
  assign commit     = res_valid && res_ready;
  assign chan_we    = commit && ((kind_r == rcc_pkg::KIND_SAMPLE && ch_ok_r)
                                 || (kind_r == rcc_pkg::KIND_TICK && failsafe));
  assign trim_we    = commit && kind_r == rcc_pkg::KIND_CALIB && ch_ok_r;
  assign chan_wdata = (kind_r == rcc_pkg::KIND_TICK) ? rcc_pkg::FAILSAFE_THR : new_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      step_r     <= STEP_THR;
      rd_pend_r  <= 1'b0;
      rd_tag_r   <= STEP_THR;
      quality_r  <= rcc_pkg::QUAL_GOOD;
      wanted_r   <= '0;
      pending_r  <= rcc_pkg::PEND_NONE;
      chan_vld_r <= '0;
      trim_vld_r <= '0;
    end else begin
      rd_pend_r <= (state_r == S_READ);
      rd_tag_r  <= step_r;
      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            state_r <= S_READ;
            step_r  <= STEP_THR;
          end
        end
        S_READ: begin
          if (kind_r == rcc_pkg::KIND_FRAME && step_r != STEP_TEST) step_r <= step_r + 4'd1;
          else state_r <= S_LAST;
        end
        S_LAST: state_r <= S_CALC;
        S_CALC: begin
          if (res_ready) begin
            state_r   <= S_IDLE;
            quality_r <= quality_nxt;
            wanted_r  <= wanted_nxt;
            pending_r <= pending_nxt;
            if (kind_r == rcc_pkg::KIND_TICK && failsafe) begin
              // throttle holds the failsafe value, every other channel reads zero
              chan_vld_r <= CHANNEL_COUNT'(1);
            end else if (chan_we) begin
              chan_vld_r[wr_addr] <= 1'b1;
            end
            if (trim_we) trim_vld_r[wr_addr] <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rc_channel_conditioner_mode_select_top.sv =====
// top level of the rc channel conditioner with flight mode selection
// Conditions raw receiver channel samples into q.14 values (deadzone, scale, invert,
// trim, saturation), grades link quality, runs the arming sticks and mode switches,
// and forces the failsafe on a late tick. Requests are taken one at a time: sample,
// calibrate, tick and mode requests take a single read step, a frame-done request
// walks every read step, because the channel memory has one read port and the mode logic
// reads nine channels through it one per cycle. A finished result sits in the output
// register while the next request is accepted. Channel and trim memories read as zero
// until written, so no clearing pass follows reset.
`default_nettype none
module rc_channel_conditioner_mode_select_top #(
  parameter int CHANNEL_COUNT = 14
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rcc_in_if.sink                      in_chan,
  rcc_out_if.source                   out_chan,
  input  logic                        cfg_we,
  input  logic [rcc_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [rcc_pkg::CFG_DW-1:0]  cfg_wdata
);

  rcc_pkg::cfg_t cfg;
  rcc_pkg::res_t res;
  rcc_pkg::res_t out_data_r;
  logic          res_valid;
  logic          res_ready;
  logic          out_valid_r;

  rcc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rcc_core #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_chan   (in_chan),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register, refilled in the cycle it drains
  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_data_r <= res;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.channel_value  = out_data_r.channel_value;
  assign out_chan.signal_quality = out_data_r.signal_quality;
  assign out_chan.desired_mode   = out_data_r.desired_mode;
  assign out_chan.merged_mode    = out_data_r.merged_mode;

endmodule
`default_nettype wire
